// File: design/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("assertion failed");

// antecedent implies consequent on the next edge
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error("assertion failed");

`endif

// File: design/pbb_pkg.sv
package pbb_pkg;
   localparam int CoordFracBits = 16;
   localparam int PixelFracBits = 4;
   localparam logic [15:0] FocalReset = 16'd10791;
   localparam logic [11:0] WidthReset = 12'd1280;
   localparam logic [11:0] HeightReset = 12'd720;
   localparam logic [1:0] CSR_FOCAL_H = 2'd0;
   localparam logic [1:0] CSR_FOCAL_V = 2'd1;
   localparam logic [1:0] CSR_WIDTH = 2'd2;
   localparam logic [1:0] CSR_HEIGHT = 2'd3;
   localparam int QueueDepth = 4;

   // one projected corner handed from front to back
   typedef struct packed {
      logic        front;
      logic signed [31:0] u;
      logic signed [31:0] v;
      logic [3:0]  class_id;
      logic        last;
   } point_type;
endpackage

// File: design/pbb_divider.sv
// restoring divider, one quotient bit a cycle, magnitudes then sign fix
module pbb_divider import pbb_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [48:0] numer,
   input  logic        [30:0] denom,
   output logic               busy,
   output logic               done,
   output logic signed [48:0] quot
);
   logic [47:0] q_ff, q_in;
   logic [30:0] r_ff, r_in, d_ff, d_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [31:0] trial;
   logic [31:0] diff;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; neg_in = neg_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff, q_ff[47]};
      diff = trial - {1'b0, d_ff};
      if (start) begin
         neg_in = numer[48];
         q_in = numer[48] ? 48'(-numer) : numer[47:0];
         r_in = '0; d_in = denom; cnt_in = 6'd48; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[31]) begin
            r_in = diff[30:0];
            q_in = {q_ff[46:0], 1'b1};
         end else begin
            r_in = trial[30:0];
            q_in = {q_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; neg_ff <= neg_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
endmodule

// File: design/pbb_front.sv
`include "assert_macros.svh"
// front: multiply, divide twice, offset, saturate a corner in front
module pbb_front import pbb_pkg::*; #(
   parameter int PIXEL_FRAC_BITS = PixelFracBits
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic [31:0] depth,
   input  logic [31:0] lateral,
   input  logic [31:0] elevation,
   input  logic [3:0]  class_id,
   input  logic        last,
   input  logic [15:0] focal_h,
   input  logic [15:0] focal_v,
   input  logic [11:0] width,
   input  logic [11:0] height,
   output logic        out_valid,
   input  logic        out_ready,
   output point_type   out_point
);
   localparam logic [1:0] ST_IDLE = 2'd0, ST_DIVU = 2'd1, ST_DIVV = 2'd2,
                          ST_OUT = 2'd3;
   logic [1:0]  st_ff, st_in;
   logic signed [48:0] nu_ff, nv_ff, uq_ff, nu_in, nv_in, uq_in;
   logic [30:0] den_ff, den_in;
   logic [3:0]  cls_ff, cls_in;
   logic        last_ff, last_in;
   point_type   pt_ff, pt_in;
   logic        dstart;
   logic signed [48:0] dnum;
   logic        dbusy, ddone;
   logic signed [48:0] dq;
   logic        kick_ff;
   logic        start_mux;
   logic signed [48:0] num_mux;

   function automatic logic signed [31:0] sat_add(input logic signed [48:0] q,
                                                  input logic [11:0] size);
      logic signed [49:0] s;
      logic [20:0] half;
      begin
         half = 21'(({9'd0, size} << PIXEL_FRAC_BITS) >> 1);
         s = 50'(q) + $signed({29'd0, half});
         if (s > 50'sd2147483647) sat_add = 32'sh7fffffff;
         else if (s < -50'sd2147483648) sat_add = 32'sh80000000;
         else sat_add = s[31:0];
      end
   endfunction

   // first division is kicked the cycle after capture, the second on its done
   assign start_mux = kick_ff | dstart;
   assign num_mux = kick_ff ? nu_ff : dnum;

   pbb_divider u_div (
      .clock(clock), .reset(reset), .start(start_mux), .numer(num_mux),
      .denom(den_ff), .busy(dbusy), .done(ddone), .quot(dq)
   );

   assign in_ready = (st_ff == ST_IDLE);
   assign out_valid = (st_ff == ST_OUT);
   assign out_point = pt_ff;

   always_comb begin
      st_in = st_ff; nu_in = nu_ff; nv_in = nv_ff; uq_in = uq_ff;
      den_in = den_ff; cls_in = cls_ff; last_in = last_ff;
      pt_in = pt_ff; dstart = 1'b0; dnum = nu_ff;
      unique case (st_ff)
         ST_IDLE: begin
            if (in_valid) begin
               nu_in = -(49'($signed({1'b0, focal_h})) * 49'($signed(lateral)));
               nv_in = 49'($signed({1'b0, focal_v})) * 49'($signed(elevation));
               den_in = depth[30:0];
               cls_in = class_id; last_in = last;
               if (!depth[31] && depth != 32'd0) begin
                  st_in = ST_DIVU;
               end else begin
                  pt_in = '{front: 1'b0, u: '0, v: '0, class_id: class_id, last: last};
                  st_in = ST_OUT;
               end
            end
         end
         ST_DIVU: begin
            if (ddone) begin
               uq_in = dq; st_in = ST_DIVV;
               dstart = 1'b1; dnum = nv_ff;
            end
         end
         ST_DIVV: begin
            if (ddone) begin
               pt_in = '{front: 1'b1, u: sat_add(uq_ff, width), v: sat_add(dq, height),
                         class_id: cls_ff, last: last_ff};
               st_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_ready) st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   // division starts the cycle after capture
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE; kick_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         kick_ff <= (st_ff == ST_IDLE) && (st_in == ST_DIVU);
      end
      nu_ff <= nu_in; nv_ff <= nv_in; uq_ff <= uq_in; den_ff <= den_in;
      cls_ff <= cls_in; last_ff <= last_in; pt_ff <= pt_in;
   end

   `ASSERT_ALWAYS(a_start_when_idle, clock, reset, !start_mux || !dbusy)
   `ASSERT_NEXT(a_out_hold, clock, reset, out_valid && !out_ready, out_valid && $stable(out_point))
endmodule

// File: design/pbb_fifo.sv
`include "assert_macros.svh"
// short queue between front and back
module pbb_fifo import pbb_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      wr_valid,
   output logic      wr_ready,
   input  point_type wr_data,
   output logic      rd_valid,
   input  logic      rd_ready,
   output point_type rd_data
);
   point_type mem_ff [QueueDepth];
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;
   logic wr, rd;
   assign wr_ready = cnt_ff != 3'(QueueDepth);
   assign rd_valid = cnt_ff != 3'd0;
   assign rd_data = mem_ff[rp_ff];
   assign wr = wr_valid && wr_ready;
   assign rd = rd_valid && rd_ready;
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= wp_ff + 2'd1;
         if (rd) rp_ff <= rp_ff + 2'd1;
         cnt_ff <= cnt_ff + 3'(wr) - 3'(rd);
      end
      if (wr) mem_ff[wp_ff] <= wr_data;
   end

   `ASSERT_ALWAYS(a_cnt_bound, clock, reset, cnt_ff <= 3'(QueueDepth))
   `ASSERT_NEXT(a_rd_hold, clock, reset, rd_valid && !rd_ready, rd_valid && $stable(rd_data))
endmodule

// File: design/pbb_back.sv
`include "assert_macros.svh"
// back: running extremes and box result
module pbb_back import pbb_pkg::*; #(
   parameter int PIXEL_FRAC_BITS = PixelFracBits
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        restart,
   input  logic [11:0] width,
   input  logic [11:0] height,
   input  logic        in_valid,
   output logic        in_ready,
   input  point_type   in_point,
   output logic        out_valid,
   input  logic        out_ready,
   output logic [68:0] out_data
);
   logic signed [31:0] minu_ff, maxu_ff, minv_ff, maxv_ff;
   logic front_ff, inside_ff, ov_ff;
   logic [68:0] od_ff;
   logic signed [31:0] ws, hs, u, v, nminu, nmaxu, nminv, nmaxv;
   logic uin, vin, nfront, ninside, ok;
   logic signed [31:0] l, r, b, t;
   logic take;

   function automatic logic span_ok(input logic signed [31:0] lo, hi, lim,
                                    output logic signed [31:0] clo, chi);
      logic signed [33:0] full, cs;
      begin
         clo = lo < 0 ? 32'sd0 : lo;
         chi = hi > lim ? lim : hi;
         full = 34'(hi) - 34'(lo);
         cs = 34'(chi) - 34'(clo);
         if (full[33]) full = -full;
         if (cs[33]) cs = -cs;
         span_ok = (full == 0) || ({cs, 3'b0} >= {3'b0, full});
      end
   endfunction

   assign ws = 32'({20'd0, width} << PIXEL_FRAC_BITS);
   assign hs = 32'({20'd0, height} << PIXEL_FRAC_BITS);
   assign in_ready = !ov_ff || out_ready;
   assign take = in_valid && in_ready;
   assign out_valid = ov_ff;
   assign out_data = od_ff;

   always_comb begin
      u = in_point.u; v = in_point.v;
      uin = !u[31] && u <= ws;
      vin = !v[31] && v <= hs;
      nminu = minu_ff; nmaxu = maxu_ff; nminv = minv_ff; nmaxv = maxv_ff;
      nfront = front_ff; ninside = inside_ff;
      if (in_point.front) begin
         nfront = 1'b1;
         if (uin && vin) ninside = 1'b1;
         if (vin) begin
            if (u < nminu) nminu = u;
            if (u > nmaxu) nmaxu = u;
         end
         if (uin) begin
            if (v < nminv) nminv = v;
            if (v > nmaxv) nmaxv = v;
         end
      end
      ok = span_ok(nminu, nmaxu, ws, l, r);
      ok = span_ok(nminv, nmaxv, hs, b, t) && ok && nfront && ninside;
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         front_ff <= 1'b0; inside_ff <= 1'b0;
         minu_ff <= ws; maxu_ff <= '0; minv_ff <= hs; maxv_ff <= '0;
      end else if (take) begin
         if (in_point.last) begin
            front_ff <= 1'b0; inside_ff <= 1'b0;
            minu_ff <= ws; maxu_ff <= '0; minv_ff <= hs; maxv_ff <= '0;
         end else begin
            front_ff <= nfront; inside_ff <= ninside;
            minu_ff <= nminu; maxu_ff <= nmaxu; minv_ff <= nminv; maxv_ff <= nmaxv;
         end
      end
      if (reset) ov_ff <= 1'b0;
      else if (take && in_point.last) ov_ff <= 1'b1;
      else if (out_ready) ov_ff <= 1'b0;
      if (take && in_point.last) begin
         od_ff <= ok ? {t[15:0], b[15:0], r[15:0], l[15:0], in_point.class_id, 1'b1}
                     : {64'd0, in_point.class_id, 1'b0};
      end
   end

   `ASSERT_NEXT(a_rsp_hold, clock, reset, out_valid && !out_ready, out_valid && $stable(out_data))
endmodule

// File: design/projected_bounding_box.sv
// a last corner behind the camera skips the divider; a last corner in front
// passes two 48-step divisions in the bit-serial divider of the front stage,
// then the handoff; the front stage takes a new corner only once it has handed
// the last one to the queue
// reset: synchronous, restores register defaults and clears the box state
module projected_bounding_box import pbb_pkg::*; #(
   parameter int PIXEL_FRAC_BITS = PixelFracBits
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [103:0] req_tdata,  // depth, lateral, elevation, class_id
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // box_valid, class_id_out, left, right, bottom, top
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   logic [15:0] fh_ff, fv_ff;
   logic [11:0] w_ff, h_ff;
   logic f_valid, f_ready, q_valid, q_ready;
   logic restart_ff, restart_in;
   point_type f_pt, q_pt;
   logic [68:0] od;

   assign csr_ready = 1'b1;
   assign restart_in = csr_valid && csr_ready &&
                       (csr_index == CSR_WIDTH || csr_index == CSR_HEIGHT);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fh_ff <= FocalReset; fv_ff <= FocalReset; w_ff <= WidthReset; h_ff <= HeightReset;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_FOCAL_H: fh_ff <= csr_data;
            CSR_FOCAL_V: fv_ff <= csr_data;
            CSR_WIDTH:   w_ff <= csr_data[11:0];
            CSR_HEIGHT:  h_ff <= csr_data[11:0];
            default: ;
         endcase
      end
   end

   // box restart is registered from a size write, so it comes once the new size is in place
   always_ff @(posedge clock) begin
      if (reset) restart_ff <= 1'b0;
      else restart_ff <= restart_in;
   end

   pbb_front #(.PIXEL_FRAC_BITS(PIXEL_FRAC_BITS)) u_front (
      .clock(clock), .reset(reset), .in_valid(req_tvalid), .in_ready(req_tready),
      .depth(req_tdata[31:0]), .lateral(req_tdata[63:32]),
      .elevation(req_tdata[95:64]), .class_id(req_tdata[99:96]), .last(req_tlast),
      .focal_h(fh_ff), .focal_v(fv_ff), .width(w_ff), .height(h_ff),
      .out_valid(f_valid), .out_ready(f_ready), .out_point(f_pt)
   );

   pbb_fifo u_fifo (
      .clock(clock), .reset(reset), .wr_valid(f_valid), .wr_ready(f_ready),
      .wr_data(f_pt), .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_pt)
   );

   pbb_back #(.PIXEL_FRAC_BITS(PIXEL_FRAC_BITS)) u_back (
      .clock(clock), .reset(reset), .restart(restart_ff), .width(w_ff), .height(h_ff),
      .in_valid(q_valid), .in_ready(q_ready), .in_point(q_pt),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(od)
   );

   assign rsp_tdata = {3'd0, od};
endmodule
